// File: rtl/insertion_sorter_top_macros.svh
// Assertion macros shared by the insertion sorter checker.
`ifndef INSERTION_SORTER_TOP_MACROS_SVH
`define INSERTION_SORTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISORT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("insertion sorter check failed");

// The consequent must hold in the cycle after the antecedent.
`define ISORT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("insertion sorter check failed");

`endif

// File: rtl/isort_pkg.sv
// Shared types for the insertion sorter: state codes, commands and status.
package isort_pkg;

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_INS        = 7'b0000010,
    ST_CMP        = 7'b0000100,
    ST_PLACE      = 7'b0001000,
    ST_EMIT_START = 7'b0010000,
    ST_EMIT_LD    = 7'b0100000,
    ST_EMIT_HOLD  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic ld_in;
    logic rd_prev;
    logic write_v;
    logic shift;
    logic set_ovf;
    logic emit_start;
    logic emit_load;
    logic emit_next;
    logic list_clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic pos_one;
    logic greater;
    logic last_in;
    logic out_last;
    logic out_taken;
  } sts_t;

endpackage

// File: rtl/insertion_sorter_top.sv
// Top level of the stable insertion sorter for lists of signed 32-bit values.
// An item passes ST_INS, and ST_CMP unless the store is empty or full; each larger entry moves
// up in its own ST_CMP step, since the single store read port is walked one entry per cycle.
// After a final item, each sorted result is loaded in ST_EMIT_LD and held in ST_EMIT_HOLD
// while out_stall is high.
// Synchronous active-low reset empties the list and clears overflow; no clearing pass is run.
module insertion_sorter_top #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value_res,
  output logic               out_last_res,
  output logic               out_overflow
);

  isort_pkg::cmd_t cmd;
  isort_pkg::sts_t sts;

  isort_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  isort_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res),
    .out_overflow (out_overflow),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// File: rtl/isort_ram.sv
// Generic single write port RAM with one registered read port.
module isort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/isort_ctrl.sv
// Controller state machine for the insertion sorter.
module isort_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  isort_pkg::sts_t sts,
  output isort_pkg::cmd_t cmd
);

  isort_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isort_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      isort_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = isort_pkg::ST_INS;
        end
      end
      isort_pkg::ST_INS: begin
        if (sts.full) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = sts.last_in ? isort_pkg::ST_EMIT_START : isort_pkg::ST_IDLE;
        end else if (sts.cnt_zero) begin
          cmd.write_v = 1'b1;
          state_nxt   = sts.last_in ? isort_pkg::ST_EMIT_START : isort_pkg::ST_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = isort_pkg::ST_CMP;
        end
      end
      isort_pkg::ST_CMP: begin
        if (sts.greater) begin
          cmd.shift = 1'b1;
          state_nxt = sts.pos_one ? isort_pkg::ST_PLACE : isort_pkg::ST_CMP;
        end else begin
          cmd.write_v = 1'b1;
          state_nxt   = sts.last_in ? isort_pkg::ST_EMIT_START : isort_pkg::ST_IDLE;
        end
      end
      isort_pkg::ST_PLACE: begin
        cmd.write_v = 1'b1;
        state_nxt   = sts.last_in ? isort_pkg::ST_EMIT_START : isort_pkg::ST_IDLE;
      end
      isort_pkg::ST_EMIT_START: begin
        cmd.emit_start = 1'b1;
        state_nxt      = isort_pkg::ST_EMIT_LD;
      end
      isort_pkg::ST_EMIT_LD: begin
        cmd.emit_load = 1'b1;
        state_nxt     = isort_pkg::ST_EMIT_HOLD;
      end
      isort_pkg::ST_EMIT_HOLD: begin
        if (sts.out_taken) begin
          if (sts.out_last) begin
            cmd.list_clear = 1'b1;
            state_nxt      = isort_pkg::ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = isort_pkg::ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_nxt = isort_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != isort_pkg::ST_IDLE);

endmodule

// File: rtl/isort_dp.sv
// Datapath for the insertion sorter: sorted store, counters and result register.
module isort_dp #(
  parameter int DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic signed [31:0]     in_value,
  input  logic                   in_last,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic signed [31:0]     out_value_res,
  output logic                   out_last_res,
  output logic                   out_overflow,
  input  isort_pkg::cmd_t        cmd,
  output isort_pkg::sts_t        sts
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] val_r;
  logic               last_r;
  logic [AW-1:0]      pos_r;
  logic [AW-1:0]      idx_r;
  logic [CW-1:0]      cnt_r;
  logic               ovf_r;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_last_r;
  logic               out_ovf_r;

  logic               wr_en;
  logic [31:0]        wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  assign wr_en   = cmd.write_v | cmd.shift;
  assign wr_data = cmd.shift ? rd_data : val_r;
  assign rd_en   = cmd.rd_prev | cmd.shift | cmd.emit_start | cmd.emit_next;

  always_comb begin
    rd_addr = idx_r;
    if (cmd.emit_start) begin
      rd_addr = '0;
    end else if (cmd.rd_prev) begin
      rd_addr = pos_r - AW'(1);
    end else if (cmd.shift) begin
      rd_addr = pos_r - AW'(2);
    end
  end

  isort_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(pos_r),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      val_r  <= in_value;
      last_r <= in_last;
      pos_r  <= cnt_r[AW-1:0];
    end else if (cmd.shift) begin
      pos_r <= pos_r - AW'(1);
    end
    if (cmd.emit_start) begin
      idx_r <= '0;
    end else if (cmd.emit_load) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.emit_load) begin
      out_value_r <= $signed(rd_data);
      out_last_r  <= ((CW'(idx_r) + CW'(1)) == cnt_r);
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.list_clear) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        if (cmd.write_v) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (cmd.set_ovf) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.full      = (cnt_r == CW'(DEPTH));
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.pos_one   = (pos_r == AW'(1));
  assign sts.greater   = ($signed(rd_data) > val_r);
  assign sts.last_in   = last_r;
  assign sts.out_last  = out_last_r;
  assign sts.out_taken = out_valid_r & ~out_stall;

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;
  assign out_overflow  = out_ovf_r;

endmodule

// File: rtl/isort_checker.sv
// Port-level checker for the insertion sorter and its bind to the top level.
`include "insertion_sorter_top_macros.svh"

module isort_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] in_value,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_value_res,
  input logic               out_last_res,
  input logic               out_overflow
);

  `ISORT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(out_value_res) && $stable(out_last_res) && $stable(out_overflow))
  `ISORT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
                     in_valid && $stable(in_value) && $stable(in_last))
  `ISORT_ASSERT_SAME(a_no_input_while_emitting, clk, rst_n, out_valid, in_stall)
  `ISORT_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)
  `ISORT_ASSERT_NEXT(a_no_result_before_last, clk, rst_n,
                     in_valid && !in_stall && !in_last, !out_valid)

endmodule

bind insertion_sorter_top isort_checker u_isort_checker (.*);

// File: bench/insertion_sorter_top_tb.sv
// Self-checking testbench for insertion_sorter_top: directed and random lists.
module insertion_sorter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam longint TIMEOUT_NS = 4_000_000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef enum int {VALUES_WIDE, VALUES_CLUSTERED, VALUES_EDGE} value_mode_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               overflow;
  } sorted_entry_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_value = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_value_res;
  logic               out_last_res;
  logic               out_overflow;

  logic receiver_hold = 1'b0;
  event hold_start;
  int   send_gap_pct = 30;
  int   recv_stall_pct = 59;
  int   error_count = 0;

  logic signed [31:0] list_store [DEPTH];
  int                 list_count = 0;
  logic               list_dropped = 1'b0;
  sorted_entry_t      sorted_q [$];

  insertion_sorter_top #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value(in_value),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value_res(out_value_res),
    .out_last_res(out_last_res),
    .out_overflow(out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void sort_insert(logic signed [31:0] v, logic is_last);
    int pos;
    sorted_entry_t entry;
    if (list_count < DEPTH) begin
      pos = list_count;
      while (pos > 0 && list_store[pos - 1] > v) begin
        list_store[pos] = list_store[pos - 1];
        pos--;
      end
      list_store[pos] = v;
      list_count++;
    end else begin
      list_dropped = 1'b1;
    end
    if (is_last) begin
      for (int k = 0; k < list_count; k++) begin
        entry.value = list_store[k];
        entry.last = (k == list_count - 1);
        entry.overflow = list_dropped;
        sorted_q.insert(sorted_q.size(), entry);
      end
      list_count = 0;
      list_dropped = 1'b0;
    end
  endfunction

  function automatic logic signed [31:0] pick_value(value_mode_t mode);
    case (mode)
      VALUES_WIDE: return $urandom;
      VALUES_CLUSTERED: return int'($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 4))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return VAL_MAX - int'($urandom_range(0, 3));
          3: return VAL_MIN + int'($urandom_range(0, 3));
          default: return int'($urandom_range(0, 2)) - 1;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_item(logic signed [31:0] v, logic is_last);
    in_valid <= 1'b1;
    in_value <= v;
    in_last <= is_last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sort_insert(v, is_last);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_list(int len, value_mode_t mode);
    for (int i = 0; i < len; i++) begin
      send_item(pick_value(mode), (i == len - 1));
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sorted_q.size() != 0);
  endtask

  task automatic test_directed_lists();
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(5, 1'b0);
    send_item(5, 1'b0);
    send_item(-5, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_item(100 - 30 * i, (i == 7));
    end
    for (int i = 0; i < 4; i++) begin
      send_item(i - 2, (i == 3));
    end
    send_item(VAL_MAX, 1'b1);
    idle_input();
    wait_drained();
  endtask

  task automatic test_capacity();
    send_list(DEPTH, VALUES_WIDE);
    idle_input();
    wait_drained();
    send_list(DEPTH + 2, VALUES_CLUSTERED);
    idle_input();
    wait_drained();
  endtask

  task automatic test_random_lists(int gap_pct, int stall_pct, int item_budget);
    int sent;
    int len;
    int pick;
    sent = 0;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    while (sent < item_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        len = $urandom_range(1, 12);
      end else if (pick < 95) begin
        len = $urandom_range(13, 40);
      end else begin
        len = $urandom_range(DEPTH - 2, DEPTH + 4);
      end
      send_list(len, value_mode_t'($urandom_range(0, 2)));
      sent += len;
      if ($urandom_range(0, 9) == 0) begin
        idle_input();
        wait_drained();
      end
    end
    idle_input();
    wait_drained();
  endtask

  task automatic test_output_hold();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    -> hold_start;
    for (int i = 0; i < 4; i++) begin
      send_list(6, VALUES_WIDE);
    end
    idle_input();
    wait_drained();
  endtask

  always begin
    @(hold_start);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= receiver_hold || ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    sorted_entry_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result transfer, value %0d", out_value_res));
      end else begin
        want = sorted_q.pop_front();
        if (out_value_res !== want.value) begin
          report_mismatch($sformatf("value %0d, expected %0d", out_value_res, want.value));
        end
        if (out_last_res !== want.last) begin
          report_mismatch($sformatf("last flag %b, expected %b", out_last_res, want.last));
        end
        if (out_overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow flag %b, expected %b", out_overflow,
                                    want.overflow));
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("insertion_sorter_top_tb failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_lists();
    test_capacity();
    test_random_lists(30, 59, 75);
    test_random_lists(59, 30, 75);
    test_random_lists(0, 0, 70);
    test_output_hold();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && sorted_q.size() == 0) begin
      $display("insertion_sorter_top_tb passed");
    end else begin
      $display("insertion_sorter_top_tb failed");
    end
    $finish;
  end

endmodule
